// ===== hdl/kt_pkg.sv =====
package kt_pkg;

  localparam int Capacity = 256;
  localparam int PayloadBits = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int KeyW = 64;
  localparam int EntW = KeyW + PayloadBits;

  localparam logic [2:0] OpLookup = 3'd0;
  localparam logic [2:0] OpAdd    = 3'd1;
  localparam logic [2:0] OpDelete = 3'd2;
  localparam logic [2:0] OpUpdate = 3'd3;
  localparam logic [2:0] OpUpsert = 3'd4;
  localparam logic [2:0] OpRead   = 3'd5;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StPresent  = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StRange    = 3'd4;

  // memory port request from the sequencer
  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [EntW-1:0] wdata;
  } mem_req_t;

endpackage

// ===== hdl/kt_ram.sv =====
module kt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/kt_seq.sv =====
module kt_seq import kt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data_i,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             op_i,
  input  logic [KeyW-1:0]        key_i,
  input  logic [31:0]            payload_i,
  input  logic [7:0]             position_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             status_o,
  output logic [KeyW-1:0]        found_key_o,
  output logic [31:0]            found_payload_o,
  output logic [7:0]             found_position_o,
  output mem_req_t               mreq_o,
  input  logic [EntW-1:0]        rdata_i
);

  typedef enum logic [3:0] {
    SIdle, SFind, SFindWait, SDecide, SInsScan, SInsWait, SShiftUp, SShiftUpWr,
    SDelRd, SDelWr, SReadWait, SDone
  } state_e;

  state_e state_q;
  logic sorted_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0] op_q;
  logic [KeyW-1:0] key_q;
  logic [PayloadBits-1:0] pl_q;
  logic [7:0] pos_q;
  // search window / scan index
  logic [CntW-1:0] lo_q, hi_q, idx_q;
  logic [CntW-1:0] mid;
  logic found_q;
  logic [CntW-1:0] at_q;
  logic [2:0] st_q;
  logic [KeyW-1:0] fk_q;
  logic [31:0] fp_q;
  logic [7:0] fpos_q;
  logic ov_q;
  // result register, separate from the working registers
  logic [2:0] out_st_q;
  logic [KeyW-1:0] out_key_q;
  logic [31:0] out_pl_q;
  logic [7:0] out_pos_q;
  logic done_fire;

  logic [KeyW-1:0] rkey;
  logic [PayloadBits-1:0] rpl;
  assign rkey = rdata_i[EntW-1 -: KeyW];
  assign rpl  = rdata_i[PayloadBits-1:0];
  assign mid  = lo_q + ((hi_q - lo_q) >> 1);

  // finished item moves to the result register once it is free
  assign done_fire = (state_q == SDone) && (!ov_q || !out_stall);

  assign cfg_ready = (state_q == SIdle) && !ov_q;
  assign in_stall  = !((state_q == SIdle) && !cfg_valid);
  assign out_valid = ov_q;
  assign status_o = out_st_q;
  assign found_key_o = out_key_q;
  assign found_payload_o = out_pl_q;
  assign found_position_o = out_pos_q;

  // memory port drive
  always_comb begin
    mreq_o = '0;
    case (state_q)
      SFind: begin
        mreq_o.re = 1'b1;
        mreq_o.raddr = sorted_q ? mid[IdxW-1:0] : idx_q[IdxW-1:0];
      end
      SInsScan: begin
        mreq_o.re = 1'b1;
        mreq_o.raddr = idx_q[IdxW-1:0];
      end
      SShiftUp: begin
        mreq_o.re = 1'b1;
        mreq_o.raddr = idx_q[IdxW-1:0] - 1'b1;
      end
      SShiftUpWr: begin
        mreq_o.we = 1'b1;
        mreq_o.waddr = idx_q[IdxW-1:0];
        mreq_o.wdata = rdata_i;
      end
      SDelRd: begin
        mreq_o.re = 1'b1;
        mreq_o.raddr = sorted_q ? (idx_q[IdxW-1:0] + 1'b1) : (cnt_q[IdxW-1:0] - 1'b1);
      end
      SDelWr: begin
        mreq_o.we = 1'b1;
        mreq_o.waddr = idx_q[IdxW-1:0];
        mreq_o.wdata = rdata_i;
      end
      SDecide: begin
        // payload rewrite in place
        if (found_q && (op_q == OpUpdate || op_q == OpUpsert)) begin
          mreq_o.we = 1'b1;
          mreq_o.waddr = at_q[IdxW-1:0];
          mreq_o.wdata = {key_q, pl_q};
        end
        if (op_q == OpRead) begin
          mreq_o.re = 1'b1;
          mreq_o.raddr = pos_q[IdxW-1:0];
        end
      end
      SDone: begin
        // final write of a new entry
        if (st_q == StOk && !found_q && (op_q == OpAdd || op_q == OpUpsert)) begin
          mreq_o.we = 1'b1;
          mreq_o.waddr = at_q[IdxW-1:0];
          mreq_o.wdata = {key_q, pl_q};
        end
      end
      default: ;
    endcase
  end

  // sequencer and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      sorted_q <= 1'b1;
      cnt_q <= '0;
      ov_q <= 1'b0;
      out_st_q <= '0;
      out_key_q <= '0;
      out_pl_q <= '0;
      out_pos_q <= '0;
    end else begin
      if (done_fire) ov_q <= 1'b1;
      else if (ov_q && !out_stall) ov_q <= 1'b0;
      if (done_fire) begin
        out_st_q <= st_q;
        out_key_q <= fk_q;
        out_pl_q <= fp_q;
        out_pos_q <= fpos_q;
      end
      case (state_q)
        SIdle: begin
          if (cfg_valid && cfg_ready) begin
            sorted_q <= cfg_data_i;
            cnt_q <= '0;
          end else if (in_valid && !in_stall) begin
            op_q <= op_i;
            key_q <= key_i;
            pl_q <= payload_i[PayloadBits-1:0];
            pos_q <= position_i;
            lo_q <= '0;
            hi_q <= cnt_q;
            idx_q <= '0;
            found_q <= 1'b0;
            at_q <= '0;
            st_q <= StOk;
            fk_q <= '0;
            fp_q <= '0;
            fpos_q <= '0;
            if (op_i == OpRead || op_i > OpRead) state_q <= SDecide;
            else state_q <= SFind;
          end
        end
        SFind: begin
          if (sorted_q ? (lo_q >= hi_q) : (idx_q >= cnt_q)) state_q <= SDecide;
          else begin
            at_q <= sorted_q ? mid : idx_q;
            state_q <= SFindWait;
          end
        end
        SFindWait: begin
          if (rkey == key_q) begin
            found_q <= 1'b1;
            fk_q <= rkey;
            fp_q <= 32'(rpl);
            state_q <= SDecide;
          end else begin
            state_q <= SFind;
            if (sorted_q) begin
              if (rkey < key_q) lo_q <= at_q + 1'b1;
              else hi_q <= at_q;
            end else idx_q <= idx_q + 1'b1;
          end
        end
        SDecide: begin
          state_q <= SDone;
          case (op_q)
            OpLookup: begin
              if (found_q) fpos_q <= 8'(at_q);
              else st_q <= StNotFound;
            end
            OpAdd, OpUpsert: begin
              fk_q <= '0;
              fp_q <= '0;
              if (found_q) begin
                if (op_q == OpAdd) st_q <= StPresent;
              end else if (cnt_q >= CntW'(Capacity)) st_q <= StFull;
              else if (sorted_q) begin
                idx_q <= '0;
                at_q <= cnt_q;
                state_q <= SInsScan;
              end else at_q <= cnt_q;
            end
            OpDelete: begin
              fk_q <= '0;
              fp_q <= '0;
              if (!found_q) st_q <= StNotFound;
              else begin
                idx_q <= at_q;
                if (sorted_q ? (at_q + 1'b1 < cnt_q) : (at_q + 1'b1 != cnt_q))
                  state_q <= SDelRd;
                else cnt_q <= cnt_q - 1'b1;
              end
            end
            OpUpdate: begin
              fk_q <= '0;
              fp_q <= '0;
              if (!found_q) st_q <= StNotFound;
            end
            OpRead: begin
              if ({1'b0, pos_q} < 9'(cnt_q)) begin
                fpos_q <= pos_q;
                state_q <= SReadWait;
              end else st_q <= StRange;
            end
            default: ;
          endcase
        end
        SReadWait: begin
          fk_q <= rkey;
          fp_q <= 32'(rpl);
          state_q <= SDone;
        end
        // find the first key above the new one
        SInsScan: begin
          if (idx_q >= cnt_q) begin
            at_q <= cnt_q;
            idx_q <= cnt_q;
            state_q <= SShiftUp;
          end else state_q <= SInsWait;
        end
        SInsWait: begin
          if (rkey > key_q) begin
            at_q <= idx_q;
            idx_q <= cnt_q;
            state_q <= SShiftUp;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= SInsScan;
          end
        end
        // move entries up one slot, top down
        SShiftUp: begin
          if (idx_q <= at_q) state_q <= SDone;
          else state_q <= SShiftUpWr;
        end
        SShiftUpWr: begin
          idx_q <= idx_q - 1'b1;
          state_q <= SShiftUp;
        end
        SDelRd: state_q <= SDelWr;
        SDelWr: begin
          if (sorted_q && (idx_q + 2'd2 < cnt_q)) begin
            idx_q <= idx_q + 1'b1;
            state_q <= SDelRd;
          end else begin
            cnt_q <= cnt_q - 1'b1;
            state_q <= SDone;
          end
        end
        // hold here while the previous result is still waiting
        SDone: begin
          if (done_fire) begin
            if (st_q == StOk && !found_q && (op_q == OpAdd || op_q == OpUpsert))
              cnt_q <= cnt_q + 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

// ===== hdl/keyed_table_sorted_or_unsorted.sv =====
// Channel  Direction  Handshake          Beat
// cfg      in         cfg_valid/ready    sorted_mode_i (write clears table)
// in       in         in_valid/in_stall  op_i, key_i, payload_i, position_i
// out      out        out_valid/stall    status_o, found_key_o, found_payload_o,
//                                        found_position_o
// One item at a time; entry RAM has read and write ports, one access a cycle.
// Lookup is a binary search sorted and a linear scan unsorted; sorted add
// and delete scan and shift entries one at a time.
// Reset empties the table and selects sorted mode; no clearing pass.
// A result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds in its last cycle until the register frees.
module keyed_table_sorted_or_unsorted import kt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        sorted_mode_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [31:0] payload_i,
  input  logic [7:0]  position_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status_o,
  output logic [63:0] found_key_o,
  output logic [31:0] found_payload_o,
  output logic [7:0]  found_position_o
);

  mem_req_t mreq;
  logic [EntW-1:0] rdata;

  kt_seq u_seq (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_data_i(sorted_mode_i),
    .in_valid, .in_stall, .op_i, .key_i, .payload_i, .position_i,
    .out_valid, .out_stall, .status_o, .found_key_o, .found_payload_o,
    .found_position_o, .mreq_o(mreq), .rdata_i(rdata)
  );

  // entry store: key over payload
  kt_ram #(.Width(EntW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(mreq.we), .waddr_i(mreq.waddr), .wdata_i(mreq.wdata),
    .re_i(mreq.re), .raddr_i(mreq.raddr), .rdata_o(rdata)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import kt_pkg::*;

  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam logic [63:0] KeyOnes = '1;
  localparam logic [63:0] KeyMid = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KeyLow = 64'h7fff_ffff_ffff_ffff;
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] key;
    logic [31:0] payload;
    logic [7:0]  position;
  } reply_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key;
    logic [31:0] payload;
    logic [7:0]  position;
    logic        typed;
    reply_t      exp;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        sorted_mode_i = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op_i = '0;
  logic [63:0] key_i = '0;
  logic [31:0] payload_i = '0;
  logic [7:0]  position_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] found_key_o;
  logic [31:0] found_payload_o;
  logic [7:0]  found_position_o;

  keyed_table_sorted_or_unsorted i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .sorted_mode_i   (sorted_mode_i),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op_i            (op_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .position_i      (position_i),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status_o        (status_o),
    .found_key_o     (found_key_o),
    .found_payload_o (found_payload_o),
    .found_position_o(found_position_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the table
  logic [63:0]    tbl_key [Capacity];
  logic [31:0]    tbl_pay [Capacity];
  int             tbl_count = 0;
  logic           tbl_sorted = 1'b1;

  request_t       offered_ops [$];
  reply_t         expected_replies [$];
  int             errors = 0;
  int             n_requests = 0;
  int             n_replies = 0;
  int             n_mode_writes = 0;
  int             idle_cycles = 0;
  bit             hold_req = 1'b0;
  logic [63:0]    key_pool [16];

  // directed requests; typed rows carry the reply read straight off the spec
  request_t dir_tab [24] = '{
    '{OpLookup, 64'd0, 32'd0, 8'd0, 1'b1, '{StNotFound, 64'd0, 32'd0, 8'd0}},
    '{OpRead, 64'd0, 32'd0, 8'd0, 1'b1, '{StRange, 64'd0, 32'd0, 8'd0}},
    '{OpSpare6, KeyOnes, 32'hffff_ffff, 8'hff, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpSpare7, KeyMid, 32'h1, 8'h1, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpAdd, 64'd0, 32'd0, 8'd0, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpAdd, KeyOnes, 32'hffff_ffff, 8'd0, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpAdd, 64'd0, 32'h1234, 8'd0, 1'b1, '{StPresent, 64'd0, 32'd0, 8'd0}},
    '{OpAdd, KeyMid, 32'ha5a5_a5a5, 8'd0, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpLookup, KeyOnes, 32'd0, 8'd0, 1'b0, '0},
    '{OpRead, 64'd0, 32'd0, 8'd0, 1'b0, '0},
    '{OpRead, 64'd0, 32'd0, 8'd1, 1'b0, '0},
    '{OpRead, 64'd0, 32'd0, 8'd2, 1'b0, '0},
    '{OpRead, 64'd0, 32'd0, 8'd3, 1'b1, '{StRange, 64'd0, 32'd0, 8'd0}},
    '{OpRead, 64'd0, 32'd0, 8'd255, 1'b1, '{StRange, 64'd0, 32'd0, 8'd0}},
    '{OpUpdate, 64'd5, 32'd7, 8'd0, 1'b1, '{StNotFound, 64'd0, 32'd0, 8'd0}},
    '{OpUpdate, KeyMid, 32'h5a5a_5a5a, 8'd0, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpLookup, KeyMid, 32'd0, 8'd0, 1'b0, '0},
    '{OpUpsert, KeyOnes, 32'd0, 8'd0, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpUpsert, KeyLow, 32'hffff_0000, 8'd0, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpDelete, 64'd5, 32'd0, 8'd0, 1'b1, '{StNotFound, 64'd0, 32'd0, 8'd0}},
    '{OpDelete, 64'd0, 32'd0, 8'd0, 1'b1, '{StOk, 64'd0, 32'd0, 8'd0}},
    '{OpLookup, 64'd0, 32'd0, 8'd0, 1'b1, '{StNotFound, 64'd0, 32'd0, 8'd0}},
    '{OpRead, 64'd0, 32'd0, 8'd0, 1'b0, '0},
    '{OpLookup, KeyLow, 32'd0, 8'd0, 1'b0, '0}
  };

  // adds a key known to be absent, shifting in sorted mode
  function automatic logic [2:0] table_insert(logic [63:0] k, logic [31:0] p);
    int at;
    if (tbl_count >= Capacity) return StFull;
    at = tbl_count;
    if (tbl_sorted) begin
      at = 0;
      while (at < tbl_count && tbl_key[at] <= k) at++;
      for (int i = tbl_count; i > at; i--) begin
        tbl_key[i] = tbl_key[i-1];
        tbl_pay[i] = tbl_pay[i-1];
      end
    end
    tbl_key[at] = k;
    tbl_pay[at] = p;
    tbl_count++;
    return StOk;
  endfunction

  // applies one request to the shadow table and returns the reply
  function automatic reply_t table_apply(request_t rq);
    reply_t r;
    int     at;
    bit     hit;
    r = '0;
    at = 0;
    hit = 1'b0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == rq.key) begin
        hit = 1'b1;
        at = i;
      end
    end
    case (rq.op)
      OpLookup: begin
        if (hit) begin
          r.key = tbl_key[at];
          r.payload = tbl_pay[at];
          r.position = at[7:0];
        end else r.status = StNotFound;
      end
      OpAdd: begin
        if (hit) r.status = StPresent;
        else r.status = table_insert(rq.key, rq.payload);
      end
      OpDelete: begin
        if (!hit) r.status = StNotFound;
        else begin
          if (tbl_sorted) begin
            for (int i = at; i < tbl_count - 1; i++) begin
              tbl_key[i] = tbl_key[i+1];
              tbl_pay[i] = tbl_pay[i+1];
            end
          end else begin
            tbl_key[at] = tbl_key[tbl_count-1];
            tbl_pay[at] = tbl_pay[tbl_count-1];
          end
          tbl_count--;
        end
      end
      OpUpdate: begin
        if (hit) tbl_pay[at] = rq.payload;
        else r.status = StNotFound;
      end
      OpUpsert: begin
        if (hit) tbl_pay[at] = rq.payload;
        else r.status = table_insert(rq.key, rq.payload);
      end
      OpRead: begin
        if (int'(rq.position) < tbl_count) begin
          r.key = tbl_key[rq.position];
          r.payload = tbl_pay[rq.position];
          r.position = rq.position;
        end else r.status = StRange;
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic request_t rand_request();
    request_t rq;
    int       r;
    rq = '0;
    r = $urandom_range(0, 99);
    rq.op = (r < 4) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    rq.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 15)]
                                          : {$urandom, $urandom};
    rq.payload = $urandom;
    rq.position = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                              : 8'($urandom_range(0, 20));
    return rq;
  endfunction

  // offers one request and returns at the edge where it is taken
  task automatic offer(request_t rq);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_i <= rq.op;
    key_i <= rq.key;
    payload_i <= rq.payload;
    position_i <= rq.position;
    offered_ops.push_back(rq);
    do @(posedge clk_i); while (!(in_valid && !in_stall));
  endtask

  // mode write once the table has gone quiet; clears the table
  task automatic write_mode(logic v);
    in_valid <= 1'b0;
    while (offered_ops.size() != 0 || expected_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid <= 1'b1;
    sorted_mode_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    tbl_sorted = v;
    tbl_count = 0;
    n_mode_writes++;
    cfg_valid <= 1'b0;
  endtask

  // request side: predict at acceptance
  always @(posedge clk_i) begin
    request_t rq;
    reply_t   pr;
    if (rst_ni && in_valid && !in_stall) begin
      rq = offered_ops.pop_front();
      pr = table_apply(rq);
      expected_replies.push_back(rq.typed ? rq.exp : pr);
      n_requests++;
    end
  end

  // reply side: field by field against the oldest expectation
  always @(posedge clk_i) begin
    reply_t ex;
    if (rst_ni && out_valid && !out_stall) begin
      n_replies++;
      if (expected_replies.size() == 0) begin
        $error("unexpected reply beat, status %0d", status_o);
        errors++;
      end else begin
        ex = expected_replies.pop_front();
        if (status_o !== ex.status) begin
          $error("status: expected %0d, got %0d", ex.status, status_o);
          errors++;
        end
        if (found_key_o !== ex.key) begin
          $error("found_key: expected %h, got %h", ex.key, found_key_o);
          errors++;
        end
        if (found_payload_o !== ex.payload) begin
          $error("found_payload: expected %h, got %h", ex.payload, found_payload_o);
          errors++;
        end
        if (found_position_o !== ex.position) begin
          $error("found_position: expected %0d, got %0d", ex.position, found_position_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    request_t rq;
    key_pool[0] = '0;
    key_pool[1] = KeyOnes;
    key_pool[2] = KeyMid;
    key_pool[3] = KeyLow;
    for (int i = 4; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, sorted mode from reset
    foreach (dir_tab[i]) offer(dir_tab[i]);

    // unsorted: fill to capacity, refuse further adds, then swap-removes
    write_mode(1'b0);
    for (int i = 0; i < Capacity; i++) begin
      rq = '0;
      rq.op = (i % 2) ? OpUpsert : OpAdd;
      rq.key = (i < 2) ? key_pool[i] : {$urandom, $urandom};
      rq.payload = $urandom;
      offer(rq);
    end
    rq = '0;
    rq.op = OpAdd;
    rq.key = 64'h1234_5678_9abc_def0;
    offer(rq);
    rq.op = OpUpsert;
    offer(rq);
    rq.op = OpAdd;
    rq.key = KeyOnes;
    offer(rq);
    rq.op = OpRead;
    rq.position = 8'd255;
    offer(rq);
    rq.op = OpUpsert;
    rq.payload = 32'hdead_beef;
    offer(rq);
    for (int i = 0; i < 8; i++) begin
      rq = '0;
      rq.op = (i % 2) ? OpLookup : OpDelete;
      rq.key = (i < 2) ? '0 : tbl_key[$urandom_range(0, tbl_count - 1)];
      offer(rq);
    end

    // sorted, random traffic over a small key pool with one long hold-off
    write_mode(1'b1);
    for (int i = 0; i < 150; i++) begin
      if (i == 60) hold_req = 1'b1;
      offer(rand_request());
    end

    // unsorted again, random traffic
    write_mode(1'b0);
    for (int i = 0; i < 50; i++) offer(rand_request());
    in_valid <= 1'b0;

    while (offered_ops.size() != 0 || expected_replies.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests, %0d replies checked, %0d mode writes.",
             n_requests, n_replies, n_mode_writes);
    $display("Both modes exercised, unsorted fill to capacity, output hold-off.");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/kt_pkg.sv
hdl/kt_ram.sv
hdl/kt_seq.sv
hdl/keyed_table_sorted_or_unsorted.sv
tb/tb_top.sv
